// File: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion that is switched off while reset is high
`define MTGE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("check failed in %m");

// clocked assertion that also holds during reset
`define MTGE_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("check failed in %m");

`endif

// File: sv/mtge_pkg.sv
// shared types and constants of the markup text glyph emitter
package mtge_pkg;

   // default parameter values
   localparam int STACK_DEPTH_DEF = 8;
   localparam int COORD_BITS_DEF  = 12;

   // fixed field widths
   localparam int CODE_BITS    = 8;
   localparam int SCREEN_BITS  = 12;
   localparam int ATLAS_BITS   = 10;
   localparam int SIZE_BITS    = 7;
   localparam int COLOR_BITS   = 32;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;

   // digit buffer of a color code
   localparam int MAX_HELD      = 7;
   localparam int HELD_IDX_BITS = 3;

   // command queue between parser and emitter
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CODE_BITS-1:0]  ESC_BYTE = 8'd124;
   localparam logic [COLOR_BITS-1:0] WHITE    = 32'hFFFF_FFFF;

   // register reset values
   localparam logic [SCREEN_BITS-1:0] ORIGIN_X_RST     = 12'd0;
   localparam logic [SCREEN_BITS-1:0] ORIGIN_Y_RST     = 12'd0;
   localparam logic [SIZE_BITS-1:0]   GLYPH_WIDTH_RST  = 7'd8;
   localparam logic [SIZE_BITS-1:0]   GLYPH_HEIGHT_RST = 7'd12;
   localparam logic [CODE_BITS-1:0]   RESET_CODE_RST   = 8'd114;
   localparam logic [CODE_BITS-1:0]   NEWLINE_CODE_RST = 8'd110;
   localparam logic [CODE_BITS-1:0]   COLOR_CODE_RST   = 8'd99;

   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_ESC,
      MODE_COLOR
   } parse_mode_type;

   typedef enum logic [2:0] {
      REG_ORIGIN_X,
      REG_ORIGIN_Y,
      REG_GLYPH_WIDTH,
      REG_GLYPH_HEIGHT,
      REG_RESET_CODE,
      REG_NEWLINE_CODE,
      REG_COLOR_CODE
   } reg_index_type;

   // configuration seen by parser and emitter
   typedef struct packed {
      logic [SCREEN_BITS-1:0] origin_x;
      logic [SCREEN_BITS-1:0] origin_y;
      logic [SIZE_BITS-1:0]   glyph_width;
      logic [SIZE_BITS-1:0]   glyph_height;
      logic [CODE_BITS-1:0]   reset_code;
      logic [CODE_BITS-1:0]   newline_code;
      logic [CODE_BITS-1:0]   color_code;
   } cfg_type;

   // one draw command: a run of glyphs sharing row and color
   typedef struct packed {
      logic [MAX_HELD-1:0][CODE_BITS-1:0] codes;
      logic [HELD_IDX_BITS-1:0]           last_idx;
      logic [COLOR_BITS-1:0]              color;
   } glyph_cmd_type;

endpackage

// File: sv/mtge_ifs.sv
// item channel interfaces: text bytes in, glyph records out
interface mtge_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_text;

   modport source (output valid, char_byte, end_of_text, input ready);
   modport sink (input valid, char_byte, end_of_text, output ready);
endinterface

interface mtge_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  glyph;
   logic [11:0] screen_x;
   logic [11:0] screen_y;
   logic [9:0]  atlas_x;
   logic [9:0]  atlas_y;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  alpha;
   logic        last_of_run;

   modport source (output valid, glyph, screen_x, screen_y, atlas_x, atlas_y,
                   red, green, blue, alpha, last_of_run, input ready);
   modport sink (input valid, glyph, screen_x, screen_y, atlas_x, atlas_y,
                 red, green, blue, alpha, last_of_run, output ready);
endinterface

// File: sv/mtge_front.sv
// parser: classifies text bytes, keeps cursor and color stack, issues draw commands
module mtge_front
   import mtge_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   in_valid,
   input  logic [CODE_BITS-1:0]   in_char,
   input  logic                   in_last,
   output logic                   in_ready,
   output logic                   out_valid,
   input  logic                   out_ready,
   output glyph_cmd_type          out_cmd,
   output logic [COORD_BITS-1:0]  out_x,
   output logic [COORD_BITS-1:0]  out_y
);

   localparam int CW  = $clog2(STACK_DEPTH + 1);
   localparam int IDX = $clog2(STACK_DEPTH);

   parse_mode_type           mode_ff, mode_in;
   logic [HELD_IDX_BITS-1:0] dc_ff, dc_in;
   logic [COLOR_BITS-1:0]    acc_ff, acc_in;
   logic [CODE_BITS-1:0]     held_ff [MAX_HELD];
   logic [CW-1:0]            count_ff, count_in;
   logic [COLOR_BITS-1:0]    top_ff, top_in;
   logic [COORD_BITS-1:0]    cx_ff, cx_in;
   logic [COORD_BITS-1:0]    cy_ff, cy_in;

   // color stack memory, entry zero is never written, the white base comes from WHITE
   logic [COLOR_BITS-1:0]    stack_mem [STACK_DEPTH];
   logic [COLOR_BITS-1:0]    below_ff;
   logic [IDX-1:0]           below_addr;
   logic                     wr_en;
   logic [IDX-1:0]           wr_addr;

   logic                     accept;
   logic                     emit;
   logic                     held_we;
   logic [COLOR_BITS-1:0]    acc_shift;
   logic [COORD_BITS-1:0]    width_ext;
   logic [COORD_BITS-1:0]    height_ext;

   function automatic logic [3:0] hex_value(input logic [CODE_BITS-1:0] b);
      logic [3:0] v;
      v = 4'd0;
      if (b >= 8'd48 && b <= 8'd57) begin
         v = 4'(b - 8'd48);
      end else if (b >= 8'd97 && b <= 8'd102) begin
         v = 4'(b - 8'd87);
      end else if (b >= 8'd65 && b <= 8'd70) begin
         v = 4'(b - 8'd55);
      end
      return v;
   endfunction

   assign in_ready   = out_ready;
   assign accept     = in_valid & in_ready;
   assign out_valid  = accept & emit;
   assign out_x      = cx_ff;
   assign out_y      = cy_ff;
   assign width_ext  = COORD_BITS'(cfg.glyph_width);
   assign height_ext = COORD_BITS'(cfg.glyph_height);
   assign acc_shift  = {acc_ff[COLOR_BITS-5:0], hex_value(in_char)};
   assign below_addr = IDX'(count_ff - CW'(2));

   // command payload: held digits first, then the current byte
   always_comb begin
      for (int i = 0; i < MAX_HELD; i++) begin
         out_cmd.codes[i] = (HELD_IDX_BITS'(i) < dc_ff) ? held_ff[i] : in_char;
      end
      out_cmd.last_idx = dc_ff;
      out_cmd.color    = top_ff;
   end

   // parse step
   always_comb begin
      mode_in  = mode_ff;
      dc_in    = dc_ff;
      acc_in   = acc_ff;
      count_in = count_ff;
      top_in   = top_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      emit     = 1'b0;
      held_we  = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = IDX'(count_ff);
      if (accept) begin
         unique case (mode_ff)
            MODE_ESC: begin
               mode_in = MODE_NORMAL;
               if (!in_last) begin
                  priority if (in_char == cfg.reset_code) begin
                     if (count_ff > CW'(1)) begin
                        count_in = count_ff - CW'(1);
                        top_in   = (count_ff == CW'(2)) ? WHITE : below_ff;
                     end
                  end else if (in_char == cfg.newline_code) begin
                     cx_in = COORD_BITS'(cfg.origin_x);
                     cy_in = cy_ff + height_ext;
                  end else if (in_char == cfg.color_code) begin
                     mode_in = MODE_COLOR;
                     dc_in   = '0;
                     acc_in  = '0;
                  end else if (in_char == ESC_BYTE) begin
                     emit  = 1'b1;
                     cx_in = cx_ff + width_ext;
                  end else begin
                     // unknown modifier is dropped
                     mode_in = MODE_NORMAL;
                  end
               end
            end
            MODE_COLOR: begin
               acc_in = acc_shift;
               if (dc_ff == HELD_IDX_BITS'(MAX_HELD)) begin
                  // eighth digit: push, overwrite the top when full
                  wr_en  = 1'b1;
                  top_in = acc_shift;
                  if (count_ff >= CW'(STACK_DEPTH)) begin
                     wr_addr = IDX'(STACK_DEPTH - 1);
                  end else begin
                     count_in = count_ff + CW'(1);
                  end
                  mode_in = MODE_NORMAL;
                  dc_in   = '0;
                  acc_in  = '0;
               end else if (in_last) begin
                  // cut-off color code flushes its digits as glyphs
                  emit = 1'b1;
               end else begin
                  held_we = 1'b1;
                  dc_in   = dc_ff + HELD_IDX_BITS'(1);
               end
            end
            MODE_NORMAL: begin
               if (in_char == ESC_BYTE && !in_last) begin
                  mode_in = MODE_ESC;
               end else begin
                  emit  = 1'b1;
                  cx_in = cx_ff + width_ext;
               end
            end
            default: begin
               mode_in = MODE_NORMAL;
            end
         endcase
         // end of string returns to origin and white
         if (in_last) begin
            mode_in  = MODE_NORMAL;
            dc_in    = '0;
            acc_in   = '0;
            count_in = CW'(1);
            top_in   = WHITE;
            cx_in    = COORD_BITS'(cfg.origin_x);
            cy_in    = COORD_BITS'(cfg.origin_y);
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         dc_ff    <= '0;
         acc_ff   <= '0;
         count_ff <= CW'(1);
         top_ff   <= WHITE;
         cx_ff    <= COORD_BITS'(ORIGIN_X_RST);
         cy_ff    <= COORD_BITS'(ORIGIN_Y_RST);
      end else begin
         mode_ff  <= mode_in;
         dc_ff    <= dc_in;
         acc_ff   <= acc_in;
         count_ff <= count_in;
         top_ff   <= top_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
      end
   end

   // held digit buffer
   always_ff @(posedge clock) begin
      if (held_we) begin
         held_ff[dc_ff] <= in_char;
      end
   end

   // stack memory, the entry below the top is read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= acc_shift;
      end
      below_ff <= stack_mem[below_addr];
   end

endmodule

// File: sv/mtge_queue.sv
// short command queue between parser and emitter
module mtge_queue
   import mtge_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  glyph_cmd_type         in_cmd,
   input  logic [COORD_BITS-1:0] in_x,
   input  logic [COORD_BITS-1:0] in_y,
   output logic                  out_valid,
   input  logic                  out_ready,
   output glyph_cmd_type         out_cmd,
   output logic [COORD_BITS-1:0] out_x,
   output logic [COORD_BITS-1:0] out_y
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   glyph_cmd_type         cmd_ff [QUEUE_DEPTH];
   logic [COORD_BITS-1:0] x_ff [QUEUE_DEPTH];
   logic [COORD_BITS-1:0] y_ff [QUEUE_DEPTH];
   logic [PW-1:0]         wp_ff, wp_in;
   logic [PW-1:0]         rp_ff, rp_in;
   logic [NW-1:0]         n_ff, n_in;
   logic                  push;
   logic                  pop;

   assign in_ready  = (n_ff != NW'(QUEUE_DEPTH));
   assign out_valid = (n_ff != '0);
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;
   assign out_cmd   = cmd_ff[rp_ff];
   assign out_x     = x_ff[rp_ff];
   assign out_y     = y_ff[rp_ff];

   // pointer and fill update
   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      n_in  = n_ff;
      if (push) begin
         wp_in = (wp_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_ff + PW'(1);
      end
      if (pop) begin
         rp_in = (rp_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_ff + PW'(1);
      end
      if (push && !pop) begin
         n_in = n_ff + NW'(1);
      end else if (pop && !push) begin
         n_in = n_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         n_ff  <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         n_ff  <= n_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wp_ff] <= in_cmd;
         x_ff[wp_ff]   <= in_x;
         y_ff[wp_ff]   <= in_y;
      end
   end

endmodule

// File: sv/mtge_back.sv
// emitter: walks each draw command and presents one glyph record per cycle unless rsp.ready stalls it
module mtge_back
   import mtge_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  glyph_cmd_type         in_cmd,
   input  logic [COORD_BITS-1:0] in_x,
   input  logic [COORD_BITS-1:0] in_y,
   mtge_rsp_if.source            rsp
);

   localparam int AP = ATLAS_BITS + 1;

   logic                     busy_ff, busy_in;
   glyph_cmd_type            cur_ff, cur_in;
   logic [HELD_IDX_BITS-1:0] k_ff, k_in;
   logic [COORD_BITS-1:0]    x_ff, x_in;
   logic [COORD_BITS-1:0]    y_ff, y_in;

   logic                     last_glyph;
   logic                     take;
   logic                     load;
   logic [CODE_BITS-1:0]     code;
   logic [AP-1:0]            ax_full;
   logic [AP-1:0]            ay_full;

   assign last_glyph = (k_ff == cur_ff.last_idx);
   assign take       = busy_ff & rsp.ready;
   assign in_ready   = ~busy_ff | (take & last_glyph);
   assign load       = in_valid & in_ready;

   // glyph record from the current command
   assign code    = cur_ff.codes[k_ff];
   assign ax_full = AP'(code[3:0]) * AP'(cfg.glyph_width);
   assign ay_full = AP'(code[7:4]) * AP'(cfg.glyph_height);

   assign rsp.valid       = busy_ff;
   assign rsp.glyph       = code;
   assign rsp.screen_x    = SCREEN_BITS'(x_ff);
   assign rsp.screen_y    = SCREEN_BITS'(y_ff);
   assign rsp.atlas_x     = ax_full[ATLAS_BITS-1:0];
   assign rsp.atlas_y     = ay_full[ATLAS_BITS-1:0];
   assign rsp.red         = cur_ff.color[31:24];
   assign rsp.green       = cur_ff.color[23:16];
   assign rsp.blue        = cur_ff.color[15:8];
   assign rsp.alpha       = cur_ff.color[7:0];
   assign rsp.last_of_run = last_glyph;

   // step through the run, load the next command as the last glyph leaves
   always_comb begin
      busy_in = busy_ff;
      cur_in  = cur_ff;
      k_in    = k_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      priority if (load) begin
         busy_in = 1'b1;
         cur_in  = in_cmd;
         k_in    = '0;
         x_in    = in_x;
         y_in    = in_y;
      end else if (take && last_glyph) begin
         busy_in = 1'b0;
      end else if (take) begin
         k_in = k_ff + HELD_IDX_BITS'(1);
         x_in = x_ff + COORD_BITS'(cfg.glyph_width);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      k_ff   <= k_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

endmodule

// File: sv/markup_text_glyph_emitter_unit.sv
// Markup text glyph emitter: one text byte per item in, glyph records out.
// A record is offered after its command passes the queue into the emitter.
// Throughput: one byte per cycle while the queue has room; a cut-off color code
// emits up to seven records, one per cycle from the emitter unless stalled.
// Reset (synchronous): registers to defaults, cursor to origin, stack to white.
module markup_text_glyph_emitter_unit
   import mtge_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   mtge_req_if.sink                 req,
   mtge_rsp_if.source               rsp,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type               cfg_ff, cfg_in;
   reg_index_type         csr_index;
   logic                  csr_write;

   logic                  f_valid;
   logic                  f_ready;
   glyph_cmd_type         f_cmd;
   logic [COORD_BITS-1:0] f_x;
   logic [COORD_BITS-1:0] f_y;
   logic                  q_valid;
   logic                  q_ready;
   glyph_cmd_type         q_cmd;
   logic [COORD_BITS-1:0] q_x;
   logic [COORD_BITS-1:0] q_y;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_ORIGIN_X:     cfg_in.origin_x     = csr_pwdata[SCREEN_BITS-1:0];
            REG_ORIGIN_Y:     cfg_in.origin_y     = csr_pwdata[SCREEN_BITS-1:0];
            REG_GLYPH_WIDTH:  cfg_in.glyph_width  = csr_pwdata[SIZE_BITS-1:0];
            REG_GLYPH_HEIGHT: cfg_in.glyph_height = csr_pwdata[SIZE_BITS-1:0];
            REG_RESET_CODE:   cfg_in.reset_code   = csr_pwdata[CODE_BITS-1:0];
            REG_NEWLINE_CODE: cfg_in.newline_code = csr_pwdata[CODE_BITS-1:0];
            REG_COLOR_CODE:   cfg_in.color_code   = csr_pwdata[CODE_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // register read mux
   always_comb begin
      unique case (csr_index)
         REG_ORIGIN_X:     csr_prdata = CSR_DATA_BITS'(cfg_ff.origin_x);
         REG_ORIGIN_Y:     csr_prdata = CSR_DATA_BITS'(cfg_ff.origin_y);
         REG_GLYPH_WIDTH:  csr_prdata = CSR_DATA_BITS'(cfg_ff.glyph_width);
         REG_GLYPH_HEIGHT: csr_prdata = CSR_DATA_BITS'(cfg_ff.glyph_height);
         REG_RESET_CODE:   csr_prdata = CSR_DATA_BITS'(cfg_ff.reset_code);
         REG_NEWLINE_CODE: csr_prdata = CSR_DATA_BITS'(cfg_ff.newline_code);
         REG_COLOR_CODE:   csr_prdata = CSR_DATA_BITS'(cfg_ff.color_code);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x     <= ORIGIN_X_RST;
         cfg_ff.origin_y     <= ORIGIN_Y_RST;
         cfg_ff.glyph_width  <= GLYPH_WIDTH_RST;
         cfg_ff.glyph_height <= GLYPH_HEIGHT_RST;
         cfg_ff.reset_code   <= RESET_CODE_RST;
         cfg_ff.newline_code <= NEWLINE_CODE_RST;
         cfg_ff.color_code   <= COLOR_CODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // parser
   mtge_front #(
      .STACK_DEPTH (STACK_DEPTH),
      .COORD_BITS  (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req.valid),
      .in_char   (req.char_byte),
      .in_last   (req.end_of_text),
      .in_ready  (req.ready),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_cmd   (f_cmd),
      .out_x     (f_x),
      .out_y     (f_y)
   );

   // command queue
   mtge_queue #(
      .COORD_BITS (COORD_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_cmd    (f_cmd),
      .in_x      (f_x),
      .in_y      (f_y),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd),
      .out_x     (q_x),
      .out_y     (q_y)
   );

   // emitter
   mtge_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (q_valid),
      .in_ready (q_ready),
      .in_cmd   (q_cmd),
      .in_x     (q_x),
      .in_y     (q_y),
      .rsp      (rsp)
   );

endmodule

// File: sv/mtge_checker.sv
// port-level checks of the glyph emitter, bound to the top level
`include "assert_macros.svh"

module mtge_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_glyph,
   input logic [11:0] rsp_screen_y,
   input logic        rsp_last,
   input logic        csr_pready
);

   // a stalled glyph record holds
   `MTGE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_glyph) && $stable(rsp_last))

   // a run continues without a gap until its last glyph
   `MTGE_ASSERT(a_run_no_gap, clock, reset, rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)

   // glyphs of one run share the same row
   `MTGE_ASSERT(a_run_same_row, clock, reset, rsp_valid && rsp_ready && !rsp_last |=> $stable(rsp_screen_y))

   // nothing offered right after reset
   `MTGE_ASSERT_NR(a_reset_idle, clock, $past(reset) |-> !rsp_valid)

   // the register port never waits
   `MTGE_ASSERT_NR(a_pready_high, clock, csr_pready)

endmodule

bind markup_text_glyph_emitter_unit mtge_checker u_mtge_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_glyph    (rsp.glyph),
   .rsp_screen_y (rsp.screen_y),
   .rsp_last     (rsp.last_of_run),
   .csr_pready   (csr_pready)
);
